@@ hw/rtl/prlp_pkg.sv @@
package prlp_pkg;

    // parse phase of the literal
    typedef enum logic [1:0] {
        PH_ZERO   = 2'd0,
        PH_LETTER = 2'd1,
        PH_DIGITS = 2'd2,
        PH_BAD    = 2'd3
    } prlp_phase_t;

    // radix of the prefix
    typedef enum logic [1:0] {
        RADIX_HEX  = 2'd0,
        RADIX_OCT  = 2'd1,
        RADIX_DEC  = 2'd2,
        RADIX_NONE = 2'd3
    } prlp_radix_t;

    // result status
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_OVERFLOW  = 2'd2
    } prlp_status_t;

    // ascii codes the front end looks for
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPR_A = 8'h41;
    localparam logic [7:0] CH_UPPR_F = 8'h46;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LOW_O  = 8'h6f;
    localparam logic [7:0] CH_LOW_D  = 8'h64;

    localparam int unsigned VALUE_W = 64;
    // headroom for value times sixteen plus a digit
    localparam int unsigned PROD_W  = VALUE_W + 4;

    // classified character passed from front to back
    typedef struct packed {
        logic        last;
        logic        is_zero;
        prlp_radix_t prefix;
        logic        digit_ok;
        logic [3:0]  digit;
    } prlp_token_t;

endpackage

@@ hw/rtl/prlp_front.sv @@
module prlp_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    output logic                push_valid,
    input  logic                push_ready,
    output prlp_pkg::prlp_token_t push_token
);
    import prlp_pkg::*;

    logic       is_dec;
    logic       is_hex_letter;
    logic [7:0] dec_off;
    logic [7:0] hex_off;

    // input handshake goes straight to the queue
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    // digit classification
    always_comb begin
        is_dec        = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
        is_hex_letter = (s_tdata >= CH_UPPR_A) && (s_tdata <= CH_UPPR_F);
        dec_off       = s_tdata - CH_ZERO;
        hex_off       = s_tdata - CH_UPPR_A + 8'd10;
    end

    // build the token
    always_comb begin
        push_token.last     = s_tlast;
        push_token.is_zero  = (s_tdata == CH_ZERO);
        push_token.digit_ok = is_dec || is_hex_letter;
        push_token.digit    = is_dec ? dec_off[3:0] : hex_off[3:0];
        if (s_tdata == CH_LOW_X) begin
            push_token.prefix = RADIX_HEX;
        end else if (s_tdata == CH_LOW_O) begin
            push_token.prefix = RADIX_OCT;
        end else if (s_tdata == CH_LOW_D) begin
            push_token.prefix = RADIX_DEC;
        end else begin
            push_token.prefix = RADIX_NONE;
        end
    end

endmodule

@@ hw/rtl/prlp_queue.sv @@
module prlp_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  prlp_pkg::prlp_token_t push_token,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output prlp_pkg::prlp_token_t pop_token
);
    import prlp_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    prlp_token_t   mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_token  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // token storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

@@ hw/rtl/prlp_back.sv @@
module prlp_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  prlp_pkg::prlp_token_t pop_token,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,
    output logic [3:0]            m_tuser
);
    import prlp_pkg::*;

    prlp_phase_t          phase_reg, phase_next;
    prlp_radix_t          radix_reg, radix_next;
    logic                 digit_seen_reg, digit_seen_next;
    logic                 ovf_reg, ovf_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;

    logic                 out_valid_reg, out_valid_next;
    prlp_status_t         out_status_reg, out_status_next;
    prlp_radix_t          out_radix_reg, out_radix_next;
    logic [VALUE_W-1:0]   out_value_reg, out_value_next;

    logic                 do_pop;
    logic                 digit_in_radix;
    logic [PROD_W-1:0]    scaled;
    logic [PROD_W-1:0]    sum;

    // pop whenever the output slot is free or being drained
    assign pop_ready = !out_valid_reg || m_tready;
    assign do_pop    = pop_valid && pop_ready;

    // digit range check for the current radix
    always_comb begin
        case (radix_reg)
            RADIX_HEX: digit_in_radix = pop_token.digit_ok;
            RADIX_OCT: digit_in_radix = pop_token.digit_ok && !pop_token.digit[3];
            RADIX_DEC: digit_in_radix = pop_token.digit_ok && (pop_token.digit <= 4'd9);
            default:   digit_in_radix = 1'b0;
        endcase
    end

    // accumulator times radix plus digit, upper bits flag overflow
    always_comb begin
        case (radix_reg)
            RADIX_HEX: scaled = {acc_reg, 4'b0000};
            RADIX_OCT: scaled = {1'b0, acc_reg, 3'b000};
            RADIX_DEC: scaled = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
            default:   scaled = '0;
        endcase
        sum = scaled + {{(PROD_W - 4){1'b0}}, pop_token.digit};
    end

    // parse step and result build
    always_comb begin
        phase_next      = phase_reg;
        radix_next      = radix_reg;
        digit_seen_next = digit_seen_reg;
        ovf_next        = ovf_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_radix_next  = out_radix_reg;
        out_value_next  = out_value_reg;

        if (do_pop) begin
            case (phase_reg)
                PH_ZERO: begin
                    phase_next = pop_token.is_zero ? PH_LETTER : PH_BAD;
                end
                PH_LETTER: begin
                    if (pop_token.prefix != RADIX_NONE) begin
                        radix_next = pop_token.prefix;
                        phase_next = PH_DIGITS;
                    end else begin
                        phase_next = PH_BAD;
                    end
                end
                PH_DIGITS: begin
                    if (!digit_in_radix) begin
                        phase_next = PH_BAD;
                    end else begin
                        digit_seen_next = 1'b1;
                        if (!ovf_reg) begin
                            if (sum[PROD_W-1:VALUE_W] != '0) begin
                                ovf_next = 1'b1;
                            end else begin
                                acc_next = sum[VALUE_W-1:0];
                            end
                        end
                    end
                end
                default: begin
                    phase_next = PH_BAD;
                end
            endcase

            // last character: emit the result and restart
            if (pop_token.last) begin
                out_valid_next = 1'b1;
                out_radix_next = radix_next;
                out_value_next = '0;
                if (phase_next != PH_DIGITS || !digit_seen_next) begin
                    out_status_next = ST_MALFORMED;
                end else if (ovf_next) begin
                    out_status_next = ST_OVERFLOW;
                end else begin
                    out_status_next = ST_OK;
                    out_value_next  = acc_next;
                end
                phase_next      = PH_ZERO;
                radix_next      = RADIX_NONE;
                digit_seen_next = 1'b0;
                ovf_next        = 1'b0;
                acc_next        = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_ZERO;
            radix_reg      <= RADIX_NONE;
            digit_seen_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            radix_reg      <= radix_next;
            digit_seen_reg <= digit_seen_next;
            ovf_reg        <= ovf_next;
            acc_reg        <= acc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_radix_reg  <= out_radix_next;
        out_value_reg  <= out_value_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = {out_radix_reg, out_status_reg};

`ifndef NO_ASSERTIONS
    // value is only reported for a clean literal
    a_value_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_status_reg != ST_OK) |-> (out_value_reg == '0))
        else $error("nonzero value on error result");

    // digits phase always carries a real radix
    a_digits_have_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DIGITS) |-> (radix_reg != RADIX_NONE))
        else $error("digits phase without radix");

    // overflow can only follow an accepted digit
    a_ovf_after_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> digit_seen_reg)
        else $error("overflow without digit");

    // last character returns the parser to its start
    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop && pop_token.last |=> (phase_reg == PH_ZERO) && (radix_reg == RADIX_NONE)
            && !ovf_reg && !digit_seen_reg && out_valid_reg)
        else $error("parser not restarted after last character");
`endif

endmodule

@@ hw/rtl/prefixed_radix_literal_parser_unit.sv @@
// channel  | dir | tdata                   | tuser                            | tlast
// s_       | in  | [7:0] character         | -                                | is_last
// m_       | out | [63:0] value            | [1:0] status, [3:2] radix_kind   | -
//
// one character word per cycle is taken and one per cycle drained while m_ accepts
// a result word follows its last character through the classify queue, then
// through the parse step and output register
// the parse step (times radix plus digit, 68-bit add) sets the clock path
// aresetn is synchronous, active low, and clears queue, parser and output valid
// a stalled m_ side fills the queue, after which s_tready drops
module prefixed_radix_literal_parser_unit #(
    // queue depth, 2 to 8
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic [3:0]  m_tuser    // [1:0] status, [3:2] radix_kind
);
    import prlp_pkg::*;

    logic        push_valid;
    logic        push_ready;
    prlp_token_t push_token;
    logic        pop_valid;
    logic        pop_ready;
    prlp_token_t pop_token;

    // classify incoming characters
    prlp_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_token (push_token)
    );

    // decoupling queue
    prlp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_token (push_token),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_token  (pop_token)
    );

    // parse and accumulate
    prlp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_token (pop_token),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
